// ===== rtl/mixer_volume_field_writer_defines.svh =====
// Assertion macros shared by the mixer volume field writer.
`ifndef MIXER_VOLUME_FIELD_WRITER_DEFINES_SVH
`define MIXER_VOLUME_FIELD_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MVFW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MVFW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mvfw_pkg.sv =====
// Types and fixed field widths shared by the mixer volume field writer.
`timescale 1ns / 1ps
`default_nettype none

package mvfw_pkg;

  // Fixed field widths of a request and of a result.
  localparam int CH_W    = 4;
  localparam int REQ_W   = 8;
  localparam int ADDR_W  = 16;
  localparam int BITS_W  = 5;
  localparam int SHIFT_W = 6;
  localparam int REG_W   = 32;
  localparam int PCTO_W  = 7;
  localparam int FIELD_N = 32;

  // Stream widths.
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 1;

  // One subchannel update request.
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic               volume_function;
    logic               relative_mode;
    logic [REQ_W-1:0]   request_value;
    logic [ADDR_W-1:0]  register_address;
    logic [BITS_W-1:0]  field_bits;
    logic [SHIFT_W-1:0] field_shift;
    logic               reversed;
    logic               card_sets_volume;
    logic [REG_W-1:0]   current_register;
    logic               last_subchannel;
  } item_t;

  // One register write result.
  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [REG_W-1:0]  write_data;
    logic              write_valid;
    logic [PCTO_W-1:0] percent;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/mixer_volume_field_writer.sv =====
// One request per cycle while the pipeline is not held by out_tready low on a full result register.
// Stages: input register, percent and product stage, rounding and merge stage, result register.
// The percent store is read and written in the product stage, so back-to-back requests
// to one channel see each other's stored percent.
// Reset clears all valid flags and sets every stored channel percent to minus one.
`timescale 1ns / 1ps
`default_nettype none

`include "mixer_volume_field_writer_defines.svh"

module mixer_volume_field_writer
  import mvfw_pkg::*;
#(
  parameter int CHANNELS       = 16,
  parameter int MAX_PERCENT    = 100,
  parameter int REGISTER_LIMIT = 255,
  parameter int SHIFT_LIMIT    = 31,
  parameter int DATA_WIDTH     = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // channel, request_value, register_address, field_bits, field_shift, reversed,
  // card_sets_volume, current_register, zero padding
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // volume_function, relative_mode
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // write_address, write_data, percent, zero padding
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // write_valid
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  localparam int PW   = $clog2(MAX_PERCENT + 1);
  localparam int PR_W = 2 * PW;

  item_t            in_item;
  logic             en_out;
  logic             en2;
  logic             en1;

  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             s2_valid_r;
  item_t            s2_item_r;
  logic             s2_chan_ok_r;
  logic [PW-1:0]    s2_pct_r;
  logic [REG_W-1:0] s2_pq_r;
  logic [PR_W-1:0]  s2_pr_r;
  logic             out_valid_r;
  result_t          out_res_r;

  logic             p_chan_ok;
  logic [PW-1:0]    p_pct;
  logic [REG_W-1:0] p_prod_q;
  logic [PR_W-1:0]  p_prod_r;
  result_t          m_res;

  // Unpack the request.
  always_comb begin
    in_item.channel          = in_tdata[3:0];
    in_item.request_value    = in_tdata[11:4];
    in_item.register_address = in_tdata[27:12];
    in_item.field_bits       = in_tdata[32:28];
    in_item.field_shift      = in_tdata[38:33];
    in_item.reversed         = in_tdata[39];
    in_item.card_sets_volume = in_tdata[40];
    in_item.current_register = in_tdata[72:41];
    in_item.volume_function  = in_tuser[0];
    in_item.relative_mode    = in_tuser[1];
    in_item.last_subchannel  = in_tlast;
  end

  // Pipeline advance: each stage moves when the one after it has room.
  assign en_out    = !out_valid_r || out_tready;
  assign en2       = !s2_valid_r || en_out;
  assign en1       = !s1_valid_r || en2;
  assign in_tready = en1;

  mvfw_percent_unit #(
    .CHANNELS   (CHANNELS),
    .MAX_PERCENT(MAX_PERCENT)
  ) u_percent (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_item_r),
    .upd_en (s1_valid_r && en2),
    .chan_ok(p_chan_ok),
    .pct    (p_pct),
    .prod_q (p_prod_q),
    .prod_r (p_prod_r)
  );

  mvfw_field_merge #(
    .MAX_PERCENT   (MAX_PERCENT),
    .REGISTER_LIMIT(REGISTER_LIMIT),
    .SHIFT_LIMIT   (SHIFT_LIMIT),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_merge (
    .item   (s2_item_r),
    .chan_ok(s2_chan_ok_r),
    .pct    (s2_pct_r),
    .prod_q (s2_pq_r),
    .prod_r (s2_pr_r),
    .res    (m_res)
  );

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_r <= in_tvalid;
      end
      if (en2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_item_r <= in_item;
    end
    if (en2) begin
      s2_item_r    <= s1_item_r;
      s2_chan_ok_r <= p_chan_ok;
      s2_pct_r     <= p_pct;
      s2_pq_r      <= p_prod_q;
      s2_pr_r      <= p_prod_r;
    end
    if (en_out) begin
      out_res_r <= m_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.percent, out_res_r.write_data, out_res_r.write_address};
  assign out_tuser  = out_res_r.write_valid;

  // Checks on the pipeline and on the result.
  `MVFW_ASSERT_IMP(a_pct_range, s2_valid_r, 32'(s2_pct_r) <= 32'(MAX_PERCENT), "percent above full scale")
  `MVFW_ASSERT_IMP(a_nowrite_zero, out_tvalid && !out_tuser[0], out_tdata[47:0] == '0, "data on a skipped write")
  `MVFW_ASSERT_IMP(a_ready_empty, !out_valid_r, in_tready, "request refused with an empty result register")
  `MVFW_ASSERT_NXT(a_s1_moves, s1_valid_r && en2, s2_valid_r, "request lost between stages")

endmodule

`default_nettype wire

// ===== rtl/mvfw_percent_unit.sv =====
// Percent calculation, per-channel percent store and field scaling products.
`timescale 1ns / 1ps
`default_nettype none

module mvfw_percent_unit
  import mvfw_pkg::*;
#(
  parameter int CHANNELS    = 16,
  parameter int MAX_PERCENT = 100
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire item_t                      item,
  input  wire logic                       upd_en,
  output logic                            chan_ok,
  output logic [$clog2(MAX_PERCENT+1)-1:0] pct,
  output logic [REG_W-1:0]                prod_q,
  output logic [2*$clog2(MAX_PERCENT+1)-1:0] prod_r
);

  localparam int PW          = $clog2(MAX_PERCENT + 1);
  localparam int PSW         = PW + 1;
  localparam int SUM_W       = ((PSW > REQ_W) ? PSW : REQ_W) + 1;
  localparam int STORE_DEPTH = (CHANNELS < 16) ? CHANNELS : 16;
  localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PQ_W        = PW + REG_W;
  localparam int PR_W        = 2 * PW;

  logic signed [PSW-1:0]   store_r [STORE_DEPTH];
  logic [IDX_W-1:0]        idx;
  logic signed [SUM_W-1:0] stored_ext;
  logic signed [SUM_W-1:0] req_ext;
  logic signed [SUM_W-1:0] raw;
  logic signed [SUM_W-1:0] clamped;
  logic [REG_W-1:0]        qb_tab [FIELD_N];
  logic [PW-1:0]           rb_tab [FIELD_N];
  logic [PQ_W-1:0]         pq_full;
  logic                    store_wr;

  // Quotient and remainder of each power of two by the full-scale percent.
  for (genvar gi = 0; gi < FIELD_N; gi++) begin : g_tab
    assign qb_tab[gi] = REG_W'((64'd1 << gi) / 64'(MAX_PERCENT));
    assign rb_tab[gi] = PW'((64'd1 << gi) % 64'(MAX_PERCENT));
  end

  assign idx     = item.channel[IDX_W-1:0];
  assign chan_ok = ({4'd0, item.channel} < 8'(CHANNELS));

  // Absolute, relative to the stored percent, or a jump for switch-like functions.
  always_comb begin
    stored_ext = SUM_W'(store_r[idx]);
    req_ext    = SUM_W'($signed(item.request_value));
    if (!item.relative_mode) begin
      raw = req_ext;
    end else if (item.volume_function) begin
      raw = stored_ext + req_ext;
    end else if (req_ext < 0) begin
      raw = '0;
    end else begin
      raw = SUM_W'(MAX_PERCENT);
    end
    if (raw < 0) begin
      clamped = '0;
    end else if (raw > SUM_W'(MAX_PERCENT)) begin
      clamped = SUM_W'(MAX_PERCENT);
    end else begin
      clamped = raw;
    end
  end

  assign pct = clamped[PW-1:0];

  // Partial products of percent times the field maximum, split by the divisor.
  assign pq_full = PQ_W'(pct) * PQ_W'(qb_tab[item.field_bits]);
  assign prod_q  = pq_full[REG_W-1:0];
  assign prod_r  = PR_W'(pct) * PR_W'(rb_tab[item.field_bits]);

  // The percent is stored only by the last subchannel of a volume request.
  assign store_wr = upd_en && chan_ok && item.volume_function && item.last_subchannel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= '1;
      end
    end else if (store_wr) begin
      store_r[idx] <= $signed({1'b0, pct});
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mvfw_field_merge.sv =====
// Field value rounding, clamp, reversal and merge into the register word.
`timescale 1ns / 1ps
`default_nettype none

module mvfw_field_merge
  import mvfw_pkg::*;
#(
  parameter int MAX_PERCENT    = 100,
  parameter int REGISTER_LIMIT = 255,
  parameter int SHIFT_LIMIT    = 31,
  parameter int DATA_WIDTH     = 32
) (
  input  wire item_t                         item,
  input  wire logic                          chan_ok,
  input  wire logic [$clog2(MAX_PERCENT+1)-1:0] pct,
  input  wire logic [REG_W-1:0]              prod_q,
  input  wire logic [2*$clog2(MAX_PERCENT+1)-1:0] prod_r,
  output result_t                            res
);

  localparam int PW         = $clog2(MAX_PERCENT + 1);
  localparam int PR_W       = 2 * PW;
  localparam int ROUND_TERM = (MAX_PERCENT >> 1) - 1;
  localparam int BIAS       = 2 * MAX_PERCENT + ROUND_TERM;
  localparam int TW         = $clog2(MAX_PERCENT * MAX_PERCENT + 3 * MAX_PERCENT + 1);
  localparam int SH         = TW + PW;
  localparam int RC_W       = SH + 1;
  localparam int PRODW      = TW + RC_W;
  localparam int QW         = PW + 2;
  localparam int FV_W       = REG_W + 2;
  localparam logic [RC_W-1:0] RECIP =
    RC_W'(((64'd1 << SH) + 64'(MAX_PERCENT) - 64'd1) / 64'(MAX_PERCENT));

  logic [TW-1:0]         t_val;
  logic [PRODW-1:0]      t_prod;
  logic [QW-1:0]         q;
  logic [FV_W-1:0]       fv_raw;
  logic [REG_W-1:0]      maxv;
  logic [REG_W-1:0]      fv_clamp;
  logic [REG_W-1:0]      fv;
  logic [63:0]           mask64;
  logic [63:0]           merged64;
  logic [DATA_WIDTH-1:0] merged_dw;
  logic [63:0]           merged_ext;
  logic                  desc_ok;
  logic [PCTO_W+PW-1:0]  pct_ext;

  // Remainder part of the rounded numerator, kept non-negative by a bias of twice the divisor.
  assign t_val  = TW'(prod_r) + TW'(BIAS) - TW'(pct);
  assign t_prod = PRODW'(t_val) * PRODW'(RECIP);
  assign q      = t_prod[SH +: QW];

  // Rounded field value; a zero percent gives zero before any reversal.
  always_comb begin
    maxv = REG_W'((33'd1 << item.field_bits) - 33'd1);
    if (pct == '0) begin
      fv_raw = '0;
    end else begin
      fv_raw = FV_W'(prod_q) + FV_W'(q) - FV_W'(2);
    end
    if (fv_raw > FV_W'(maxv)) begin
      fv_clamp = maxv;
    end else begin
      fv_clamp = fv_raw[REG_W-1:0];
    end
    fv = item.reversed ? (maxv - fv_clamp) : fv_clamp;
  end

  // Merge the shifted field into the current word, confined to the data width.
  assign mask64     = 64'(maxv) << item.field_shift;
  assign merged64   = (64'(item.current_register) & ~mask64) | (64'(fv) << item.field_shift);
  assign merged_dw  = merged64[DATA_WIDTH-1:0];
  assign merged_ext = 64'(merged_dw);

  assign desc_ok = ({16'd0, item.register_address} <= 32'(REGISTER_LIMIT)) &&
                   (item.field_bits != '0) &&
                   ({26'd0, item.field_shift} <= 32'(SHIFT_LIMIT));

  assign pct_ext = (PCTO_W + PW)'(pct);

  // Result selection: out-of-range channel, card-set percent, field write or none.
  always_comb begin
    res = '0;
    if (chan_ok) begin
      res.percent = pct_ext[PCTO_W-1:0];
      if (item.card_sets_volume) begin
        res.write_address = item.register_address;
        res.write_data    = REG_W'(pct);
        res.write_valid   = 1'b1;
      end else if (desc_ok) begin
        res.write_address = item.register_address;
        res.write_data    = merged_ext[REG_W-1:0];
        res.write_valid   = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
